// ===== rtl/core/msort_pkg.sv =====
// Shared types for the merge sorter: request payloads and merge engine status.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_res;
        logic                      overflow;
    } t_out_item;

    // Status from the merge engine to the top-level controller.
    typedef struct packed {
        logic done;
        logic bank;
    } t_merge_stat;

endpackage

`default_nettype wire

// ===== rtl/core/msort_ram.sv =====
// Simple dual-read memory bank: one write port, two read ports, registered read data.
// Depends on msort_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

module msort_ram #(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [AW-1:0]                        i_waddr,
    input  wire logic signed [msort_pkg::VALUE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                        i_raddr_a,
    input  wire logic [AW-1:0]                        i_raddr_b,
    output logic signed [msort_pkg::VALUE_W-1:0]      o_rdata_a,
    output logic signed [msort_pkg::VALUE_W-1:0]      o_rdata_b
);
    import msort_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/msort_merge.sv =====
// Bottom-up merge engine: runs passes of doubling run width between two banks.
// Depends on msort_pkg; the memory banks and their port muxing live in the top level.
`timescale 1ns / 1ps
`default_nettype none

module msort_merge #(
    parameter int MAX_ITEMS = 64,
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    localparam int CW = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [CW-1:0]                        i_count,
    output logic [AW-1:0]                             o_rd_addr_a,
    output logic [AW-1:0]                             o_rd_addr_b,
    output logic                                      o_src_bank,
    input  wire logic signed [msort_pkg::VALUE_W-1:0] i_rd_data_a,
    input  wire logic signed [msort_pkg::VALUE_W-1:0] i_rd_data_b,
    output logic                                      o_wr_en,
    output logic [AW-1:0]                             o_wr_addr,
    output logic signed [msort_pkg::VALUE_W-1:0]      o_wr_data,
    output logic                                      o_wr_bank,
    output msort_pkg::t_merge_stat                    o_stat
);
    import msort_pkg::*;

    // Sums of start, width and doubled width need headroom beyond the count.
    localparam int SW = CW + 2;

    typedef enum logic [2:0] {
        M_IDLE,
        M_PASS,
        M_RUN,
        M_READ,
        M_CMP
    } t_mstate;

    t_mstate       r_state;
    logic [CW-1:0] r_n;
    logic [SW-1:0] r_width;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_k;
    logic          r_src;
    logic          r_done;

    logic [SW-1:0] n_mid_sum;
    logic [SW-1:0] n_hi_sum;
    logic [SW-1:0] n_cnt_ext;
    logic [CW-1:0] n_mid;
    logic [CW-1:0] n_hi;
    logic [CW-1:0] n_k;
    logic          n_take_left;

    always_comb begin
        n_cnt_ext   = SW'(r_n);
        n_mid_sum   = SW'(r_lo) + r_width;
        n_hi_sum    = SW'(r_lo) + (r_width << 1);
        n_mid       = (n_mid_sum > n_cnt_ext) ? r_n : n_mid_sum[CW-1:0];
        n_hi        = (n_hi_sum > n_cnt_ext) ? r_n : n_hi_sum[CW-1:0];
        n_k         = r_k + CW'(1);
        // On equal values the right run goes first.
        n_take_left = (r_i < r_mid) && ((r_j >= r_hi) || (i_rd_data_a < i_rd_data_b));
    end

    assign o_rd_addr_a = r_i[AW-1:0];
    assign o_rd_addr_b = r_j[AW-1:0];
    assign o_src_bank  = r_src;
    assign o_wr_en     = (r_state == M_CMP);
    assign o_wr_addr   = r_k[AW-1:0];
    assign o_wr_data   = n_take_left ? i_rd_data_a : i_rd_data_b;
    assign o_wr_bank   = ~r_src;
    assign o_stat.done = r_done;
    assign o_stat.bank = r_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_count;
                        r_width <= SW'(1);
                        r_src   <= 1'b0;
                        r_state <= M_PASS;
                    end
                end
                M_PASS: begin
                    if (r_width >= n_cnt_ext) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else begin
                        r_lo    <= '0;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    // A trailing run with no partner is merged against an empty
                    // right run, which copies it into the other bank.
                    if (r_lo < r_n) begin
                        r_mid   <= n_mid;
                        r_hi    <= n_hi;
                        r_i     <= r_lo;
                        r_j     <= n_mid;
                        r_k     <= r_lo;
                        r_state <= M_READ;
                    end else begin
                        r_src   <= ~r_src;
                        r_width <= r_width << 1;
                        r_state <= M_PASS;
                    end
                end
                M_READ: begin
                    r_state <= M_CMP;
                end
                M_CMP: begin
                    if (n_take_left) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                    r_k <= n_k;
                    if (n_k == r_hi) begin
                        r_lo    <= r_hi;
                        r_state <= M_RUN;
                    end else begin
                        r_state <= M_READ;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/merge_sorter_core.sv =====
// Merge sorter: requests load at one per cycle; a last request starts the sort.
// Sorting a set of n values takes ceil(log2 n) passes, each a read, compare and write loop
// over the banks' registered read port.
// Results then leave one at a time: each is read, captured and held until the consumer is ready.
// Synchronous active-low reset clears the count, the overflow flag and all control.
// Memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter_core #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire msort_pkg::t_in_item  i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output msort_pkg::t_out_item      o_data
);
    import msort_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SORT,
        S_ORD,
        S_OCAP,
        S_OSEND
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          r_dropped;
    logic          r_fin_bank;
    logic [CW-1:0] r_oidx;
    logic          r_out_valid;
    t_out_item     r_out;

    logic                      m_start;
    logic [AW-1:0]             m_rd_a;
    logic [AW-1:0]             m_rd_b;
    logic                      m_src;
    logic signed [VALUE_W-1:0] m_rd_data_a;
    logic signed [VALUE_W-1:0] m_rd_data_b;
    logic                      m_we;
    logic [AW-1:0]             m_waddr;
    logic signed [VALUE_W-1:0] m_wdata;
    logic                      m_wbank;
    t_merge_stat               m_stat;

    logic                      n_accept;
    logic                      n_has_room;
    logic                      n_load_we;
    logic                      b0_we;
    logic                      b1_we;
    logic [AW-1:0]             b0_waddr;
    logic signed [VALUE_W-1:0] b0_wdata;
    logic [AW-1:0]             rd_a;
    logic signed [VALUE_W-1:0] b0_rdata_a;
    logic signed [VALUE_W-1:0] b0_rdata_b;
    logic signed [VALUE_W-1:0] b1_rdata_a;
    logic signed [VALUE_W-1:0] b1_rdata_b;

    assign o_ready    = (r_state == S_LOAD);
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign n_accept   = i_valid && o_ready;
    assign n_has_room = (r_count < CW'(MAX_ITEMS));
    assign n_load_we  = n_accept && n_has_room;
    assign m_start    = (r_state == S_START);

    // Bank 0 takes loaded values; during sorting both banks belong to the merge engine.
    always_comb begin
        b0_we       = n_load_we || (m_we && !m_wbank);
        b1_we       = m_we && m_wbank;
        b0_waddr    = n_load_we ? r_count[AW-1:0] : m_waddr;
        b0_wdata    = n_load_we ? i_data.value : m_wdata;
        rd_a        = (r_state == S_ORD) ? r_oidx[AW-1:0] : m_rd_a;
        m_rd_data_a = m_src ? b1_rdata_a : b0_rdata_a;
        m_rd_data_b = m_src ? b1_rdata_b : b0_rdata_b;
    end

    msort_ram #(
        .DEPTH(MAX_ITEMS)
    ) u_bank0 (
        .i_clk    (i_clk),
        .i_we     (b0_we),
        .i_waddr  (b0_waddr),
        .i_wdata  (b0_wdata),
        .i_raddr_a(rd_a),
        .i_raddr_b(m_rd_b),
        .o_rdata_a(b0_rdata_a),
        .o_rdata_b(b0_rdata_b)
    );

    msort_ram #(
        .DEPTH(MAX_ITEMS)
    ) u_bank1 (
        .i_clk    (i_clk),
        .i_we     (b1_we),
        .i_waddr  (m_waddr),
        .i_wdata  (m_wdata),
        .i_raddr_a(rd_a),
        .i_raddr_b(m_rd_b),
        .o_rdata_a(b1_rdata_a),
        .o_rdata_b(b1_rdata_b)
    );

    msort_merge #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (m_start),
        .i_count    (r_count),
        .o_rd_addr_a(m_rd_a),
        .o_rd_addr_b(m_rd_b),
        .o_src_bank (m_src),
        .i_rd_data_a(m_rd_data_a),
        .i_rd_data_b(m_rd_data_b),
        .o_wr_en    (m_we),
        .o_wr_addr  (m_waddr),
        .o_wr_data  (m_wdata),
        .o_wr_bank  (m_wbank),
        .o_stat     (m_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_fin_bank  <= 1'b0;
            r_oidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (n_accept) begin
                        if (n_has_room) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_data.last) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    if (m_stat.done) begin
                        r_fin_bank <= m_stat.bank;
                        r_oidx     <= '0;
                        r_state    <= S_ORD;
                    end
                end
                S_ORD: begin
                    r_state <= S_OCAP;
                end
                S_OCAP: begin
                    r_out.sorted_value <= r_fin_bank ? b1_rdata_a : b0_rdata_a;
                    r_out.final_res    <= (r_oidx + CW'(1) == r_count);
                    r_out.overflow     <= r_dropped;
                    r_out_valid        <= 1'b1;
                    r_state            <= S_OSEND;
                end
                S_OSEND: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out.final_res) begin
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                            r_state   <= S_LOAD;
                        end else begin
                            r_oidx  <= r_oidx + CW'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // The block never offers a result while it takes new requests.
    a_out_excl_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("result offered while accepting requests");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> (r_count == CW'(MAX_ITEMS)))
        else $error("overflow flagged with room in the store");

    a_final_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.final_res) |=> (o_ready && r_count == '0))
        else $error("block not ready for a new set after the final result");

endmodule

`default_nettype wire
